FILE: src/sqgim_pkg.sv
`default_nettype none
package sqgim_pkg;

   localparam int CordicSteps = 23;
   localparam int RootBits    = 31;

   localparam logic [2:0] CSR_CORNER_TL = 3'd0;
   localparam logic [2:0] CSR_CORNER_TR = 3'd1;
   localparam logic [2:0] CSR_CORNER_BR = 3'd2;
   localparam logic [2:0] CSR_CORNER_BL = 3'd3;
   localparam logic [2:0] CSR_DISTANCE  = 3'd4;

   function automatic logic [21:0] atan_deg(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: src/square_point_to_gimbal_angles_top.sv
`default_nettype none
// Maps a target point to a plane shift and two gimbal angles. One request may be
// started in every clock cycle; busy is never raised. Each result appears on the rsp_
// ports for a single cycle, flagged by rsp_valid, after passing through the registers
// of the sector interpolation and rounding divide, the squares, the digit-by-digit
// square root, the CORDIC and one output register.
// The receiver cannot stall the block, so results must be taken when they appear.
module square_point_to_gimbal_angles_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [13:0] req_target_x,
   input  wire logic signed [13:0] req_target_y,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_shift_x,
   output logic signed [15:0]      rsp_shift_y,
   output logic signed [15:0]      rsp_angle_x,
   output logic signed [15:0]      rsp_angle_y,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   logic [31:0] corner_ff [4];
   logic [15:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff[0] <= 32'd0;
         corner_ff[1] <= 32'd0;
         corner_ff[2] <= 32'd0;
         corner_ff[3] <= 32'd0;
         dist_ff      <= 16'd25600;
      end else if (csr_write) begin
         unique case (csr_index)
            sqgim_pkg::CSR_CORNER_TL: corner_ff[0] <= csr_data;
            sqgim_pkg::CSR_CORNER_TR: corner_ff[1] <= csr_data;
            sqgim_pkg::CSR_CORNER_BR: corner_ff[2] <= csr_data;
            sqgim_pkg::CSR_CORNER_BL: corner_ff[3] <= csr_data;
            sqgim_pkg::CSR_DISTANCE:  dist_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage 1: sector and weights.
   logic               s1v_ff;
   logic signed [15:0] s1wa_ff, s1wb_ff;
   logic [1:0]         s1ca_ff, s1cb_ff;
   logic signed [15:0] xs, ys, sum, dif;
   logic signed [15:0] wa_in, wb_in;
   logic [1:0]         ca_in, cb_in;

   always_comb begin
      xs  = 16'(req_target_x);
      ys  = 16'(req_target_y);
      sum = xs + ys;
      dif = ys - xs;
      if (!sum[15]) begin
         ca_in = 2'd1;
         wa_in = sum;
         if (dif <= 16'sd0) begin
            cb_in = 2'd2;
            wb_in = -dif;
         end else begin
            cb_in = 2'd0;
            wb_in = dif;
         end
      end else begin
         cb_in = 2'd3;
         wb_in = -sum;
         if (dif <= 16'sd0) begin
            ca_in = 2'd2;
            wa_in = -dif;
         end else begin
            ca_in = 2'd0;
            wa_in = dif;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff <= 1'b0;
      end else begin
         s1v_ff <= start;
      end
      s1wa_ff <= wa_in;
      s1wb_ff <= wb_in;
      s1ca_ff <= ca_in;
      s1cb_ff <= cb_in;
   end

   // Stage 2: four products.
   logic               s2v_ff;
   logic signed [31:0] s2p_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2v_ff <= 1'b0;
      end else begin
         s2v_ff <= s1v_ff;
      end
      s2p_ff[0] <= 32'(s1wa_ff) * 32'($signed(corner_ff[s1ca_ff][15:0]));
      s2p_ff[1] <= 32'(s1wb_ff) * 32'($signed(corner_ff[s1cb_ff][15:0]));
      s2p_ff[2] <= 32'(s1wa_ff) * 32'($signed(corner_ff[s1ca_ff][31:16]));
      s2p_ff[3] <= 32'(s1wb_ff) * 32'($signed(corner_ff[s1cb_ff][31:16]));
   end

   // Stage 3: sums as magnitudes, rounding offset added.
   logic        s3v_ff;
   logic        s3nx_ff, s3ny_ff;
   logic [32:0] s3mx_ff, s3my_ff;
   logic signed [32:0] sumx, sumy;

   always_comb begin
      sumx = 33'(s2p_ff[0]) + 33'(s2p_ff[1]);
      sumy = 33'(s2p_ff[2]) + 33'(s2p_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3v_ff <= 1'b0;
      end else begin
         s3v_ff <= s2v_ff;
      end
      s3nx_ff <= sumx[32];
      s3ny_ff <= sumy[32];
      s3mx_ff <= (sumx[32] ? 33'(-sumx) : 33'(sumx)) + 33'd6400;
      s3my_ff <= (sumy[32] ? 33'(-sumy) : 33'(sumy)) + 33'd6400;
   end

   // Stage 4: divide by 12800 = 2^9 * 25 via reciprocal of 25.
   // q0 = floor(m' * 41943 / 2^20) with m' = m >> 9 < 2^24 is at most one short,
   // so one upward correction follows.
   logic        s4v_ff;
   logic        s4nx_ff, s4ny_ff;
   logic [23:0] s4ax_ff, s4ay_ff;
   logic [39:0] s4px_ff, s4py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4v_ff <= 1'b0;
      end else begin
         s4v_ff <= s3v_ff;
      end
      s4nx_ff <= s3nx_ff;
      s4ny_ff <= s3ny_ff;
      s4ax_ff <= s3mx_ff[32:9];
      s4ay_ff <= s3my_ff[32:9];
      s4px_ff <= 40'(s3mx_ff[32:9]) * 40'd41943;
      s4py_ff <= 40'(s3my_ff[32:9]) * 40'd41943;
   end

   // Stage 5: correct quotient, apply sign and saturate.
   logic               s5v_ff;
   logic signed [15:0] s5sx_ff, s5sy_ff;
   logic signed [15:0] satx, saty;

   function automatic logic signed [15:0] fin(input logic [23:0] a, input logic [39:0] p,
                                              input logic neg);
      logic [20:0] q;
      logic [25:0] r;
      logic signed [22:0] sq;
      logic signed [15:0] o;
      q  = 21'(p[39:20]);
      r  = 26'(a) - 26'(q) * 26'd25;
      if (r >= 26'd25) begin
         q = q + 21'd1;
      end
      sq = neg ? -23'(q) : 23'(q);
      if (sq > 23'sd32767) begin
         o = 16'sd32767;
      end else if (sq < -23'sd32768) begin
         o = -16'sd32768;
      end else begin
         o = 16'(sq);
      end
      return o;
   endfunction

   always_comb begin
      satx = fin(s4ax_ff, s4px_ff, s4nx_ff);
      saty = fin(s4ay_ff, s4py_ff, s4ny_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5v_ff <= 1'b0;
      end else begin
         s5v_ff <= s4v_ff;
      end
      s5sx_ff <= satx;
      s5sy_ff <= saty;
   end

   // Shifts ride alongside the angle pipelines.
   localparam int AngLat = 56;
   logic [31:0] shd_ff [AngLat];

   always_ff @(posedge clock) begin
      shd_ff[0] <= {s5sy_ff, s5sx_ff};
      for (int k = 1; k < AngLat; k++) begin
         shd_ff[k] <= shd_ff[k-1];
      end
   end

   logic ax_valid, ay_valid;

   sqgim_angle u_angle_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5v_ff),
      .in_shift  (s5sx_ff),
      .in_other  (s5sy_ff),
      .in_dist   (dist_ff),
      .out_valid (ax_valid),
      .out_angle (rsp_angle_x)
   );

   sqgim_angle u_angle_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5v_ff),
      .in_shift  (s5sy_ff),
      .in_other  (s5sx_ff),
      .in_dist   (dist_ff),
      .out_valid (ay_valid),
      .out_angle (rsp_angle_y)
   );

   assign rsp_valid   = ax_valid;
   assign rsp_shift_x = shd_ff[AngLat-1][15:0];
   assign rsp_shift_y = shd_ff[AngLat-1][31:16];

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      ax_valid == ay_valid) else $error("angle lanes out of step");
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_x <= 16'sd23040 && rsp_angle_x >= -16'sd23040))
      else $error("angle out of range");
   a_zero_shift: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_shift_y == 16'sd0) |-> rsp_angle_y == 16'sd0)
      else $error("zero shift gave nonzero angle");

endmodule
`default_nettype wire

FILE: src/sqgim_angle.sv
`default_nettype none
module sqgim_angle (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [15:0] in_shift,
   input  wire logic        [15:0] in_other,
   input  wire logic        [15:0] in_dist,
   output logic                    out_valid,
   output logic signed [15:0]      out_angle
);

   localparam int NStg  = sqgim_pkg::CordicSteps;
   localparam int PreW  = 33;
   localparam int RemW  = 36;
   localparam int CW    = 40;

   // Stage 0: square sums.
   logic              v0_ff;
   logic              neg0_ff, zero0_ff;
   logic [15:0]       mag0_ff;
   logic [PreW-1:0]   rad0_ff;
   logic [15:0]       oth_abs;

   always_comb begin
      oth_abs = in_other[15] ? 16'(-in_other) : in_other;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      neg0_ff  <= in_shift[15];
      zero0_ff <= (in_shift == 16'sd0);
      mag0_ff  <= in_shift[15] ? 16'(-in_shift) : 16'(in_shift);
      rad0_ff  <= PreW'(32'(in_dist) * 32'(in_dist)) + PreW'(32'(oth_abs) * 32'(oth_abs));
   end

   // Square root of rad * 2^28: radicand bits consumed two per stage, 31 result bits.
   // rad < 2^33 gives root < 2^31; the 28 low zero bits make 14 extra stages.
   localparam int RStg = 31;
   logic             rv_ff   [RStg+1];
   logic             rneg_ff [RStg+1];
   logic             rzero_ff[RStg+1];
   logic [15:0]      rmag_ff [RStg+1];
   logic [61:0]      rrad_ff [RStg+1];
   logic [RemW:0]    rrem_ff [RStg+1];
   logic [30:0]      rres_ff [RStg+1];

   always_comb begin
      rv_ff[0]    = v0_ff;
      rneg_ff[0]  = neg0_ff;
      rzero_ff[0] = zero0_ff;
      rmag_ff[0]  = mag0_ff;
      rrad_ff[0]  = {1'b0, rad0_ff, 28'd0};
      rrem_ff[0]  = {(RemW+1){1'b0}};
      rres_ff[0]  = 31'd0;
   end

   for (genvar k = 0; k < RStg; k++) begin : g_root
      logic [RemW:0] trial_in;
      logic [RemW:0] rem_in;
      logic [RemW:0] cur_in;
      always_comb begin
         cur_in   = {rrem_ff[k][RemW-2:0], rrad_ff[k][61:60]};
         trial_in = {4'd0, rres_ff[k], 2'b01};
         rem_in   = (cur_in >= trial_in) ? cur_in - trial_in : cur_in;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k+1] <= 1'b0;
         end else begin
            rv_ff[k+1] <= rv_ff[k];
         end
         rneg_ff[k+1]  <= rneg_ff[k];
         rzero_ff[k+1] <= rzero_ff[k];
         rmag_ff[k+1]  <= rmag_ff[k];
         rrad_ff[k+1]  <= {rrad_ff[k][59:0], 2'b00};
         rrem_ff[k+1]  <= rem_in;
         rres_ff[k+1]  <= {rres_ff[k][29:0], (cur_in >= trial_in)};
      end
   end

   // Vectoring CORDIC.
   logic                 cv_ff  [NStg+1];
   logic                 cneg_ff[NStg+1];
   logic                 czer_ff[NStg+1];
   logic signed [CW-1:0] cx_ff  [NStg+1];
   logic signed [CW-1:0] cy_ff  [NStg+1];
   logic signed [27:0]   cz_ff  [NStg+1];

   always_comb begin
      cv_ff[0]   = rv_ff[RStg];
      cneg_ff[0] = rneg_ff[RStg];
      czer_ff[0] = rzero_ff[RStg];
      cx_ff[0]   = CW'(rres_ff[RStg]);
      cy_ff[0]   = CW'({rmag_ff[RStg], 14'd0});
      cz_ff[0]   = 28'sd0;
   end

   for (genvar i = 0; i < NStg; i++) begin : g_cordic
      logic signed [CW-1:0] dx, dy;
      logic signed [27:0]   da;
      always_comb begin
         dx = cx_ff[i] >>> i;
         dy = cy_ff[i] >>> i;
         da = 28'(sqgim_pkg::atan_deg(5'(i)));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else begin
            cv_ff[i+1] <= cv_ff[i];
         end
         cneg_ff[i+1] <= cneg_ff[i];
         czer_ff[i+1] <= czer_ff[i];
         if (!cy_ff[i][CW-1]) begin
            cx_ff[i+1] <= cx_ff[i] + dy;
            cy_ff[i+1] <= cy_ff[i] - dx;
            cz_ff[i+1] <= cz_ff[i] + da;
         end else begin
            cx_ff[i+1] <= cx_ff[i] - dy;
            cy_ff[i+1] <= cy_ff[i] + dx;
            cz_ff[i+1] <= cz_ff[i] - da;
         end
      end
   end

   // Rounding, sign and clamp.
   logic signed [27:0] zr;
   logic signed [27:0] zq;
   logic signed [27:0] zs;
   logic signed [15:0] ang_in;

   always_comb begin
      zr = cz_ff[NStg];
      if (!zr[27]) begin
         zq = (zr + 28'sd128) >>> 8;
      end else begin
         zq = -((-zr + 28'sd128) >>> 8);
      end
      zs = cneg_ff[NStg] ? -zq : zq;
      if (czer_ff[NStg]) begin
         ang_in = 16'sd0;
      end else if (zs > 28'sd23040) begin
         ang_in = 16'sd23040;
      end else if (zs < -28'sd23040) begin
         ang_in = -16'sd23040;
      end else begin
         ang_in = 16'(zs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= cv_ff[NStg];
      end
      out_angle <= ang_in;
   end

endmodule
`default_nettype wire

FILE: tb/square_point_to_gimbal_angles_checker.sv
`default_nettype none
module square_point_to_gimbal_angles_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [13:0] req_target_x,
   input  wire logic signed [13:0] req_target_y,
   input  wire logic               rsp_valid,
   input  wire logic signed [15:0] rsp_shift_x,
   input  wire logic signed [15:0] rsp_shift_y,
   input  wire logic signed [15:0] rsp_angle_x,
   input  wire logic signed [15:0] rsp_angle_y,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output int                      fail_count,
   output int                      pending_count
);

   typedef struct packed {
      logic signed [15:0] shift_x;
      logic signed [15:0] shift_y;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
   } gimbal_result_type;

   gimbal_result_type expected_gimbal_q[$];
   logic [31:0] corner_shift [4];
   logic [15:0] distance_q88;

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint saturate(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint floor_shift(longint v, int k);
      if (v >= 0) return v >>> k;
      return -((-v - 1) >>> k) - 1;
   endfunction

   function automatic longint int_root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint axis_angle(longint s, longint d, longint o);
      longint cx, cy, z, dx, dy, q;
      if (s == 0) return 0;
      cx = int_root(longint'(d * d + o * o) << 28);
      cy = (s < 0 ? -s : s) * 16384;
      z = 0;
      for (int i = 0; i < sqgim_pkg::CordicSteps; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (cy >= 0) begin
            cx += dx; cy -= dy; z += longint'(sqgim_pkg::atan_deg(5'(i)));
         end else begin
            cx -= dx; cy += dy; z -= longint'(sqgim_pkg::atan_deg(5'(i)));
         end
      end
      q = round_div(z, 256);
      if (s < 0) q = -q;
      return saturate(q, -23040, 23040);
   endfunction

   function automatic longint corner_part(int k, bit y_half);
      return y_half ? longint'($signed(corner_shift[k][31:16]))
                    : longint'($signed(corner_shift[k][15:0]));
   endfunction

   function automatic gimbal_result_type predict_gimbal(longint x, longint y);
      gimbal_result_type r;
      longint sx, sy, wa, wb;
      int ca, cb;
      sx = 0;
      sy = 0;
      if (x != 0 || y != 0) begin
         if (x + y >= 0) begin
            ca = int'(sqgim_pkg::CSR_CORNER_TR); wa = x + y;
            if (y - x <= 0) begin cb = int'(sqgim_pkg::CSR_CORNER_BR); wb = x - y; end
            else begin cb = int'(sqgim_pkg::CSR_CORNER_TL); wb = y - x; end
         end else begin
            cb = int'(sqgim_pkg::CSR_CORNER_BL); wb = -x - y;
            if (y - x <= 0) begin ca = int'(sqgim_pkg::CSR_CORNER_BR); wa = x - y; end
            else begin ca = int'(sqgim_pkg::CSR_CORNER_TL); wa = y - x; end
         end
         sx = saturate(round_div(wa * corner_part(ca, 0) + wb * corner_part(cb, 0), 12800),
                       -32768, 32767);
         sy = saturate(round_div(wa * corner_part(ca, 1) + wb * corner_part(cb, 1), 12800),
                       -32768, 32767);
      end
      r.shift_x = 16'(sx);
      r.shift_y = 16'(sy);
      r.angle_x = 16'(axis_angle(sx, longint'(distance_q88), sy));
      r.angle_y = 16'(axis_angle(sy, longint'(distance_q88), sx));
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      fail_count++;
   endtask

   assign pending_count = expected_gimbal_q.size();

   always @(posedge clock) begin
      gimbal_result_type want;
      if (reset) begin
         corner_shift = '{default: '0};
         distance_q88 = 16'd25600;
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_gimbal_q.size() == 0) begin
               $display("mismatch: result with no request outstanding");
               fail_count++;
            end else begin
               want = expected_gimbal_q.pop_front();
               if (rsp_shift_x !== want.shift_x)
                  report_mismatch("shift_x", rsp_shift_x, want.shift_x);
               if (rsp_shift_y !== want.shift_y)
                  report_mismatch("shift_y", rsp_shift_y, want.shift_y);
               if (rsp_angle_x !== want.angle_x)
                  report_mismatch("angle_x", rsp_angle_x, want.angle_x);
               if (rsp_angle_y !== want.angle_y)
                  report_mismatch("angle_y", rsp_angle_y, want.angle_y);
            end
         end
         if (start && !busy)
            expected_gimbal_q.push_back(predict_gimbal(longint'(req_target_x),
                                                       longint'(req_target_y)));
         if (csr_write) begin
            if (csr_index <= sqgim_pkg::CSR_CORNER_BL) corner_shift[csr_index] = csr_data;
            else if (csr_index == sqgim_pkg::CSR_DISTANCE) distance_q88 = csr_data[15:0];
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/tb_square_point_to_gimbal_angles_top.sv
`default_nettype none
module tb_square_point_to_gimbal_angles_top;

   logic clock = 0, reset = 1, start = 0, csr_write = 0;
   logic signed [13:0] req_target_x = 0, req_target_y = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;
   logic busy, rsp_valid;
   logic signed [15:0] rsp_shift_x, rsp_shift_y, rsp_angle_x, rsp_angle_y;
   int fail_count, pending_count;
   int cycle_count = 0;
   bit no_gaps = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   square_point_to_gimbal_angles_top uut (.*);
   square_point_to_gimbal_angles_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 200000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      csr_write <= 1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic send_point(logic signed [13:0] x, logic signed [13:0] y);
      while (!no_gaps && $urandom_range(99) < 32) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_target_x <= x;
      req_target_y <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic load_setting(int mode);
      for (int k = 0; k <= 3; k++) begin
         case (mode)
            0: write_register(3'(k), $urandom());
            1: write_register(3'(k), 32'h7FFF_8000);
            2: write_register(3'(k), 32'h8000_7FFF);
            default: write_register(3'(k), {16'($signed($urandom_range(6400)) - 3200),
                                             16'($signed($urandom_range(6400)) - 3200)});
         endcase
      end
      case (mode)
         1: write_register(sqgim_pkg::CSR_DISTANCE, 32'd0);
         2: write_register(sqgim_pkg::CSR_DISTANCE, 32'hFFFF);
         default: write_register(sqgim_pkg::CSR_DISTANCE, 32'($urandom_range(65535)));
      endcase
      write_register(3'd7, $urandom());
   endtask

   function automatic logic signed [13:0] pick_coord();
      case ($urandom_range(9))
         0: return 14'sh2000;
         1: return 14'sh1FFF;
         2: return 14'($signed($urandom_range(12800)) - 6400);
         3: return 14'd0;
         default: return 14'($urandom());
      endcase
   endfunction

   initial begin
      logic signed [13:0] px;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_point(0, 0);
      send_point(6400, 0);
      drain_results();
      write_register(sqgim_pkg::CSR_CORNER_TL, {16'sd2000, -16'sd3000});
      write_register(sqgim_pkg::CSR_CORNER_TR, {16'sd2500, 16'sd3100});
      write_register(sqgim_pkg::CSR_CORNER_BR, {-16'sd2400, 16'sd2900});
      write_register(sqgim_pkg::CSR_CORNER_BL, {-16'sd2600, -16'sd3200});
      write_register(sqgim_pkg::CSR_DISTANCE, 32'd0);
      send_point(0, 0);
      send_point(6400, 0);
      send_point(-6400, 0);
      send_point(0, 6400);
      send_point(0, -6400);
      send_point(6400, 6400);
      send_point(-6400, -6400);
      send_point(6400, -6400);
      send_point(-6400, 6400);
      send_point(14'sh1FFF, 14'sh1FFF);
      send_point(14'sh2000, 14'sh2000);
      send_point(14'sh2000, 14'sh1FFF);
      send_point(100, 0);
      send_point(0, 100);
      send_point(3, -3);
      send_point(-3, 3);
      drain_results();
      for (int phase = 0; phase < 8; phase++) begin
         load_setting(phase < 3 ? phase : (phase % 2 ? 0 : 3));
         no_gaps = (phase == 4);
         for (int n = 0; n < 240; n++) begin
            px = pick_coord();
            if ($urandom_range(19) == 0) send_point(px, -px);
            else send_point(px, pick_coord());
            if (n == 120) drain_results();
         end
         drain_results();
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: square_point_to_gimbal_angles_top.f
src/sqgim_pkg.sv
src/sqgim_angle.sv
src/square_point_to_gimbal_angles_top.sv
tb/square_point_to_gimbal_angles_checker.sv
tb/tb_square_point_to_gimbal_angles_top.sv
